// File: rtl/core/dshot_enc_pkg.sv
// Shared types, constants and the frame builder for the DShot frame encoder.
`timescale 1ns / 1ps
package dshot_enc_pkg;

  localparam int FRAME_BITS  = 16;
  localparam int TAIL_SLOTS  = 2;
  localparam int VALUE_BITS  = 11;
  localparam int CODE_BITS   = 8;
  localparam int DUTY_BITS   = 9;
  localparam int LEAD_BITS   = 4;
  localparam int NIBBLE_BITS = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_CODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONE_CODE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_XTRA = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEAD_SLOTS = 2'd3;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] zero_code;
    logic [CODE_BITS-1:0] one_code;
    logic [CODE_BITS-1:0] first_bit_extra;
    logic [LEAD_BITS-1:0] lead_slots;
  } cfg_t;

  typedef struct packed {
    logic   vld;
    frame_t frame;
  } q_item_t;

  function automatic frame_t build_frame(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS:0]    word;
    logic [NIBBLE_BITS-1:0] sum;
    word = {value, 1'b0};
    sum  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, sum};
  endfunction

endpackage

// File: rtl/core/dshot_enc_front.sv
// Input stage: accepts throttle items and registers the built frame.
`timescale 1ns / 1ps
module dshot_enc_front
  import dshot_enc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  fr_valid,
  input  logic                  fr_ready,
  output frame_t                fr_frame
);

  logic   valid_r, valid_nxt;
  frame_t frame_r, frame_nxt;

  assign in_ready = !valid_r || fr_ready;

  always_comb begin
    valid_nxt = valid_r;
    frame_nxt = frame_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        frame_nxt = build_frame(in_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    frame_r <= frame_nxt;
  end

  assign fr_valid = valid_r;
  assign fr_frame = frame_r;

endmodule

// File: rtl/core/dshot_enc_queue.sv
// Two-entry frame queue between the input stage and the code sequencer.
`timescale 1ns / 1ps
module dshot_enc_queue
  import dshot_enc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    push_ready,
  input  frame_t  push_frame,
  output q_item_t head,
  input  logic    pop,
  output logic [1:0] count
);

  frame_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  assign head.vld   = (count_r != 2'd0);
  assign head.frame = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// File: rtl/core/dshot_enc_back.sv
// Code sequencer: walks one frame's slots and drives the output register.
`timescale 1ns / 1ps
module dshot_enc_back
  import dshot_enc_pkg::*;
#(
  parameter int MAX_LEAD_SLOTS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  q_item_t              head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] out_duty,
  output logic                 out_last
);

  localparam int SLOT_MAX = MAX_LEAD_SLOTS + FRAME_BITS + TAIL_SLOTS;
  localparam int CW       = $clog2(SLOT_MAX);

  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        slot_r, slot_nxt;
  frame_t               shift_r, shift_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [DUTY_BITS-1:0] oduty_r, oduty_nxt;
  logic                 olast_r, olast_nxt;

  logic                 step, emit;
  logic [CW-1:0]        lead_ext, lead_eff, bit_end, last_slot, cur_slot;
  frame_t               cur_shift;
  logic                 in_bits, is_first, is_last;
  logic [CODE_BITS-1:0] bit_code;
  logic [DUTY_BITS-1:0] code;

  assign lead_ext  = CW'(cfg.lead_slots);
  assign lead_eff  = (lead_ext > CW'(MAX_LEAD_SLOTS)) ? CW'(MAX_LEAD_SLOTS) : lead_ext;
  assign bit_end   = lead_eff + CW'(FRAME_BITS);
  assign last_slot = bit_end + CW'(TAIL_SLOTS - 1);

  assign step      = !ovalid_r || out_ready;
  assign emit      = step && (busy_r || head.vld);
  assign pop       = step && !busy_r && head.vld;
  assign cur_slot  = busy_r ? slot_r : '0;
  assign cur_shift = busy_r ? shift_r : head.frame;

  always_comb begin
    in_bits  = (cur_slot >= lead_eff) && (cur_slot < bit_end);
    is_first = (cur_slot == lead_eff);
    is_last  = (cur_slot == last_slot);
    bit_code = cur_shift[FRAME_BITS-1] ? cfg.one_code : cfg.zero_code;
    code     = '0;
    if (in_bits) begin
      code = {1'b0, bit_code} + (is_first ? {1'b0, cfg.first_bit_extra} : '0);
    end

    busy_nxt   = busy_r;
    slot_nxt   = slot_r;
    shift_nxt  = shift_r;
    ovalid_nxt = ovalid_r;
    oduty_nxt  = oduty_r;
    olast_nxt  = olast_r;
    if (step) begin
      ovalid_nxt = emit;
    end
    if (emit) begin
      oduty_nxt = code;
      olast_nxt = is_last;
      busy_nxt  = !is_last;
      slot_nxt  = cur_slot + CW'(1);
      shift_nxt = in_bits ? {cur_shift[FRAME_BITS-2:0], 1'b0} : cur_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      slot_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      slot_r   <= slot_nxt;
      ovalid_r <= ovalid_nxt;
    end
    shift_r <= shift_nxt;
    oduty_r <= oduty_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_duty  = oduty_r;
  assign out_last  = olast_r;

endmodule

// File: rtl/core/dshot_frame_duty_encoder_core.sv
// Top level of the DShot frame encoder: configuration registers and the three stages.
//
// Each item on the in_ channel is one 11-bit throttle or command value. The
// block builds the 16-bit DShot frame (value, telemetry bit of zero, XOR
// checksum of the nibbles) and emits a run of compare codes on the out_
// channel: lead zero codes, one code per frame bit from the MSB down, and two
// zero codes, the final one with out_tlast high. A run has lead + 18 items.
// Throughput is one code per cycle while out_tready is high; runs of queued
// frames follow each other with no gap. The input stage, the queue and the
// output register lie between an accepted input item and its first code.
// An input stage and a two-entry queue hold up to three frames ahead of the
// sequencer, so in_tready stays high for three more frames while a run streams out.
// When out_tready is low the output register holds its item and the sequencer
// waits. Reset clears all queues and restores the register defaults (zero code
// 80, one code 160, first bit extra 7, lead slots 0). The cfg_ port is always
// ready; write it only while no run is in flight.
`timescale 1ns / 1ps
module dshot_frame_duty_encoder_core
  import dshot_enc_pkg::*;
#(
  parameter int MAX_LEAD_SLOTS = 15
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [15:0]             in_tdata,   // [10:0] throttle, [15:11] zero
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata,  // [8:0] duty_code, [15:9] zero
  output logic                    out_tlast,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [7:0]              cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    fr_valid, fr_ready;
  frame_t  fr_frame;
  q_item_t head;
  logic    pop;
  logic [1:0] q_count;
  logic [DUTY_BITS-1:0] duty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_CODE:  cfg_nxt.zero_code       = cfg_data;
        REG_ONE_CODE:   cfg_nxt.one_code        = cfg_data;
        REG_FIRST_XTRA: cfg_nxt.first_bit_extra = cfg_data;
        REG_LEAD_SLOTS: cfg_nxt.lead_slots      = cfg_data[LEAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_code       <= 8'd80;
      cfg_r.one_code        <= 8'd160;
      cfg_r.first_bit_extra <= 8'd7;
      cfg_r.lead_slots      <= 4'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dshot_enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_frame (fr_frame)
  );

  dshot_enc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fr_valid),
    .push_ready (fr_ready),
    .push_frame (fr_frame),
    .head       (head),
    .pop        (pop),
    .count      (q_count)
  );

  dshot_enc_back #(
    .MAX_LEAD_SLOTS (MAX_LEAD_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_duty  (duty),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(16 - DUTY_BITS){1'b0}}, duty};

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3)
    else $error("frame queue count out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 16'd0)
    else $error("final code of a run is not an idle code");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.vld)
    else $error("sequencer popped an empty queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_count == 2'd2 && fr_valid && !pop |=> fr_valid && q_count == 2'd2)
    else $error("pending frame lost while queue full");

endmodule
